FILE: rtl/core/assert_macros.svh
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/cfr_pkg.sv
package cfr_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_LEN_ERR  = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_START_VALUE   = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1,
    REG_MAX_PAYLOAD   = 2'd2
  } reg_index_t;

  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_STATUS  = 1'b1;

  localparam logic [7:0]  CRC_POLY         = 8'h31;
  localparam logic [7:0]  START_VALUE_RST  = 8'h00;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
  localparam logic [7:0]  MAX_PAYLOAD_RST  = 8'hFF;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  start_value;
    logic [15:0] timeout_ticks;
    logic [7:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] frame_addr;
    logic [7:0] frame_code;
    logic [7:0] frame_len;
    status_t    status;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cfr_cfg_regs.sv
module cfr_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output cfr_pkg::cfg_t cfg
);
  import cfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_value   <= START_VALUE_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg.max_payload   <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_START_VALUE:   cfg.start_value   <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        REG_MAX_PAYLOAD:   cfg.max_payload   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/cfr_parser.sv
module cfr_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cfr_pkg::cmd_t    cmd,
  input  logic [7:0]       rx_byte,
  input  cfr_pkg::cfg_t    cfg,
  output cfr_pkg::result_t res
);
  import cfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SOF, PH_ADDR, PH_CODE, PH_LEN, PH_PAYLOAD, PH_CRC
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  addr_reg, addr_reg_next;
  logic [7:0]  code_reg, code_reg_next;
  logic [7:0]  len_reg, len_reg_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  crc_acc, crc_acc_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [15:0] ticks_sat;
  logic [7:0]  crc_upd;
  logic [7:0]  index_inc;
  logic        emit;
  logic        emit_kind;
  logic [7:0]  emit_data;
  status_t     emit_status;

  assign crc_upd   = crc8_update(crc_acc, rx_byte);
  assign index_inc = byte_index + 8'd1;
  assign ticks_sat = (elapsed_ticks != TICKS_MAX) ? elapsed_ticks + 16'd1 : elapsed_ticks;

  always_comb begin
    phase_next         = phase;
    addr_reg_next      = addr_reg;
    code_reg_next      = code_reg;
    len_reg_next       = len_reg;
    byte_index_next    = byte_index;
    crc_acc_next       = crc_acc;
    elapsed_ticks_next = elapsed_ticks;
    emit               = 1'b0;
    emit_kind          = KIND_STATUS;
    emit_data          = 8'd0;
    emit_status        = ST_OK;
    if (cmd == CMD_START) begin
      phase_next         = PH_SOF;
      addr_reg_next      = 8'd0;
      code_reg_next      = 8'd0;
      len_reg_next       = 8'd0;
      byte_index_next    = 8'd0;
      crc_acc_next       = 8'd0;
      elapsed_ticks_next = 16'd0;
    end else if (phase != PH_IDLE) begin
      case (cmd)
        CMD_TICK: begin
          elapsed_ticks_next = ticks_sat;
          if (ticks_sat >= cfg.timeout_ticks) begin
            emit        = 1'b1;
            emit_status = ST_TIMEOUT;
            phase_next  = PH_IDLE;
          end
        end
        CMD_BYTE: begin
          case (phase)
            PH_SOF: begin
              if (rx_byte == cfg.start_value) begin
                crc_acc_next = 8'd0;
                phase_next   = PH_ADDR;
              end
            end
            PH_ADDR: begin
              addr_reg_next = rx_byte;
              crc_acc_next  = crc_upd;
              phase_next    = PH_CODE;
            end
            PH_CODE: begin
              code_reg_next = rx_byte;
              crc_acc_next  = crc_upd;
              phase_next    = PH_LEN;
            end
            PH_LEN: begin
              len_reg_next = rx_byte;
              crc_acc_next = crc_upd;
              if (rx_byte > cfg.max_payload) begin
                emit        = 1'b1;
                emit_status = ST_LEN_ERR;
                phase_next  = PH_IDLE;
              end else begin
                byte_index_next = 8'd0;
                phase_next      = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              crc_acc_next    = crc_upd;
              byte_index_next = index_inc;
              if (index_inc >= len_reg) begin
                phase_next = PH_CRC;
              end
              emit      = 1'b1;
              emit_kind = KIND_PAYLOAD;
              emit_data = rx_byte;
            end
            PH_CRC: begin
              emit        = 1'b1;
              emit_status = (rx_byte == crc_acc) ? ST_OK : ST_CRC_ERR;
              phase_next  = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.valid      = emit;
    res.kind       = emit_kind;
    res.data_byte  = emit_data;
    res.frame_addr = addr_reg_next;
    res.frame_code = code_reg_next;
    res.frame_len  = len_reg_next;
    res.status     = emit_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      addr_reg      <= 8'd0;
      code_reg      <= 8'd0;
      len_reg       <= 8'd0;
      byte_index    <= 8'd0;
      crc_acc       <= 8'd0;
      elapsed_ticks <= 16'd0;
    end else if (step) begin
      phase         <= phase_next;
      addr_reg      <= addr_reg_next;
      code_reg      <= code_reg_next;
      len_reg       <= len_reg_next;
      byte_index    <= byte_index_next;
      crc_acc       <= crc_acc_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

FILE: rtl/core/crc8_frame_receiver_core.sv
// Frame receiver: takes one beat per cycle (start, received byte or timer tick),
// skips bytes until the start value, captures address, command and length,
// passes each payload byte out as it arrives and closes the frame with one
// status beat (ok, CRC mismatch, length over limit, timeout). CRC-8 is MSB-first,
// polynomial 0x31, init 0, over address, command, length and payload.
// Sustained rate is one beat per cycle while m_tready stays high; a beat goes
// from input to result through the input register, one parser step with a full
// byte-wide CRC update and the result register. While a result waits for
// m_tready the held input beat cannot step, so s_tready drops until the output
// register frees up. Write configuration only while idle.
`include "assert_macros.svh"

module crc8_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic [1:0]  s_tuser,    // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [7:0] data_byte, [15:8] frame_addr, [23:16] frame_code,
                                  // [31:24] frame_len, [33:32] status, [39:34] zero
  output logic [0:0]  m_tuser,    // [0] out_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cfr_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       in_valid;
  cmd_t       in_cmd;
  logic [7:0] in_byte;
  logic       advance;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_data;
  logic [7:0] out_addr;
  logic [7:0] out_code;
  logic [7:0] out_len;
  status_t    out_status;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  cfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .cmd     (in_cmd),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && res.valid) begin
      out_kind   <= res.kind;
      out_data   <= res.data_byte;
      out_addr   <= res.frame_addr;
      out_code   <= res.frame_code;
      out_len    <= res.frame_len;
      out_status <= res.status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_status, out_len, out_code, out_addr, out_data};

  `ASSERT_IMPL(a_status_no_data, clk, rst, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'd0)
  `ASSERT_IMPL(a_payload_ok_status, clk, rst, m_tvalid && !m_tuser[0], m_tdata[33:32] == 2'd0)
  `ASSERT_IMPL(a_payload_has_len, clk, rst, m_tvalid && !m_tuser[0], m_tdata[31:24] != 8'd0)
  `ASSERT_NEXT(a_start_no_result, clk, rst, advance && in_cmd == CMD_START && !out_valid, !m_tvalid)

endmodule
